// ===== design/sql_like_wildcard_matcher_defines.svh =====
// Assertion macros for the SQL LIKE wildcard matcher.
`ifndef SQL_LIKE_WILDCARD_MATCHER_DEFINES_SVH
`define SQL_LIKE_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/slwm_pkg.sv =====
// Shared constants and types for the SQL LIKE wildcard matcher.
package slwm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LEN_W           = 6;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;
    localparam int NUM_WORDS       = 4;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] WILD_ONE = 8'h5F;
    localparam logic [BYTE_W-1:0] WILD_ANY = 8'h25;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_LENGTH = 3'd0;
    localparam reg_idx_t REG_WORD0  = 3'd1;

endpackage

// ===== design/slwm_cfg.sv =====
// Pattern registers on the APB port, with the per-position masks derived from them.
module slwm_cfg #(
    parameter int PATTERN_MAX = slwm_pkg::PATTERN_MAX_DEF,
    parameter int IDX_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [slwm_pkg::ADDR_W-1:0]        paddr,
    input  logic [slwm_pkg::DATA_W-1:0]        pwdata,
    output logic [slwm_pkg::DATA_W-1:0]        prdata,
    output logic [PATTERN_MAX*slwm_pkg::BYTE_W-1:0] pat_bytes,
    output logic [PATTERN_MAX-1:0]             pct_mask,
    output logic [PATTERN_MAX-1:0]             one_mask,
    output logic [PATTERN_MAX-1:0]             lit_mask,
    output logic [PATTERN_MAX:0]               start_vec,
    output logic [IDX_W-1:0]                   len_eff
);

    logic [slwm_pkg::LEN_W-1:0]  length_reg;
    logic [slwm_pkg::LEN_W-1:0]  length_next;
    logic [slwm_pkg::DATA_W-1:0] word_reg  [slwm_pkg::NUM_WORDS];
    logic [slwm_pkg::DATA_W-1:0] word_next [slwm_pkg::NUM_WORDS];

    logic [PATTERN_MAX*slwm_pkg::BYTE_W-1:0] pat_bytes_reg;
    logic [PATTERN_MAX*slwm_pkg::BYTE_W-1:0] pat_bytes_next;
    logic [PATTERN_MAX-1:0]      pct_reg;
    logic [PATTERN_MAX-1:0]      pct_next;
    logic [PATTERN_MAX-1:0]      one_reg;
    logic [PATTERN_MAX-1:0]      one_next;
    logic [PATTERN_MAX-1:0]      lit_reg;
    logic [PATTERN_MAX-1:0]      lit_next;
    logic [PATTERN_MAX:0]        start_reg;
    logic [PATTERN_MAX:0]        start_next;
    logic [PATTERN_MAX:0]        pct_ext;
    logic [IDX_W-1:0]            len_eff_reg;
    logic [IDX_W-1:0]            len_eff_next;
    logic [slwm_pkg::LEN_W-1:0]  len_sat;

    slwm_pkg::reg_idx_t          idx;
    logic                        wr;

    assign idx = paddr[5:3];
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        length_next = length_reg;
        for (int k = 0; k < slwm_pkg::NUM_WORDS; k++)
        begin
            word_next[k] = word_reg[k];
        end
        if (wr && idx == slwm_pkg::REG_LENGTH)
        begin
            length_next = pwdata[slwm_pkg::LEN_W-1:0];
        end
        for (int k = 0; k < slwm_pkg::NUM_WORDS; k++)
        begin
            if (wr && idx == slwm_pkg::REG_WORD0 + 3'(k))
            begin
                word_next[k] = pwdata;
            end
        end
    end

    // Length saturates at the pattern capacity.
    assign len_sat = (length_next > slwm_pkg::LEN_W'(PATTERN_MAX)) ?
                     slwm_pkg::LEN_W'(PATTERN_MAX) : length_next;
    assign len_eff_next = IDX_W'(len_sat);

    always_comb
    begin
        logic [slwm_pkg::BYTE_W-1:0] b;
        logic                        active;
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            b = word_next[2'(p >> 3)][(p & 7) * slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W];
            active = slwm_pkg::LEN_W'(p) < len_sat;
            pat_bytes_next[p*slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W] = b;
            pct_next[p] = active && (b == slwm_pkg::WILD_ANY);
            one_next[p] = active && (b == slwm_pkg::WILD_ONE);
            lit_next[p] = active && (b != slwm_pkg::WILD_ANY) && (b != slwm_pkg::WILD_ONE);
        end
    end

    // Start set: position 0 plus the run of leading percents.
    assign pct_ext    = {1'b0, pct_next};
    assign start_next = pct_ext ^ (pct_ext + (PATTERN_MAX+1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            for (int k = 0; k < slwm_pkg::NUM_WORDS; k++)
            begin
                word_reg[k] <= '0;
            end
            pat_bytes_reg <= '0;
            pct_reg       <= '0;
            one_reg       <= '0;
            lit_reg       <= '0;
            start_reg     <= (PATTERN_MAX+1)'(1);
            len_eff_reg   <= '0;
        end
        else
        begin
            length_reg    <= length_next;
            for (int k = 0; k < slwm_pkg::NUM_WORDS; k++)
            begin
                word_reg[k] <= word_next[k];
            end
            pat_bytes_reg <= pat_bytes_next;
            pct_reg       <= pct_next;
            one_reg       <= one_next;
            lit_reg       <= lit_next;
            start_reg     <= start_next;
            len_eff_reg   <= len_eff_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx == slwm_pkg::REG_LENGTH)
        begin
            prdata = slwm_pkg::DATA_W'(length_reg);
        end
        for (int k = 0; k < slwm_pkg::NUM_WORDS; k++)
        begin
            if (idx == slwm_pkg::REG_WORD0 + 3'(k))
            begin
                prdata = word_reg[k];
            end
        end
    end

    assign pat_bytes = pat_bytes_reg;
    assign pct_mask  = pct_reg;
    assign one_mask  = one_reg;
    assign lit_mask  = lit_reg;
    assign start_vec = start_reg;
    assign len_eff   = len_eff_reg;

endmodule

// ===== design/sql_like_wildcard_matcher.sv =====
// Top level: SQL LIKE wildcard matcher over a byte stream, one text byte per request.
// A row's result is registered into the output buffer when its last request is taken.
// Throughput: one request per cycle unless the buffer is full; the live-position update
// (byte compares plus a carry-chain closure over percent runs) is the loop behind it.
// Results wait in a two-entry output buffer, so input flow continues while one is held.
// Reset (rst_n low, asynchronous): empty pattern, live set at position 0, no row open,
// output buffer empty. No clearing pass.
`include "sql_like_wildcard_matcher_defines.svh"

module sql_like_wildcard_matcher #(
    parameter int PATTERN_MAX = slwm_pkg::PATTERN_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slwm_pkg::ADDR_W-1:0] paddr,
    input  logic [slwm_pkg::DATA_W-1:0] pwdata,
    output logic [slwm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // text input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] text_byte
    input  logic                        s_tuser,   // [0] no_byte
    input  logic                        s_tlast,   // last
    // match result
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [0] matched, [7:1] zero
);

    localparam int IDX_W = $clog2(PATTERN_MAX + 1);
    localparam int VEC_W = PATTERN_MAX + 1;

    logic [PATTERN_MAX*slwm_pkg::BYTE_W-1:0] pat_bytes;
    logic [PATTERN_MAX-1:0] pct_mask;
    logic [PATTERN_MAX-1:0] one_mask;
    logic [PATTERN_MAX-1:0] lit_mask;
    logic [VEC_W-1:0]       start_vec;
    logic [IDX_W-1:0]       len_eff;

    slwm_cfg #(
        .PATTERN_MAX (PATTERN_MAX),
        .IDX_W       (IDX_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pat_bytes (pat_bytes),
        .pct_mask  (pct_mask),
        .one_mask  (one_mask),
        .lit_mask  (lit_mask),
        .start_vec (start_vec),
        .len_eff   (len_eff)
    );

    assign pready = 1'b1;

    logic [VEC_W-1:0]       live_reg;
    logic [VEC_W-1:0]       live_next;
    logic                   in_row_reg;
    logic                   in_row_next;

    logic                   head_valid_reg;
    logic                   head_valid_next;
    logic                   head_match_reg;
    logic                   head_match_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic                   skid_match_reg;
    logic                   skid_match_next;

    logic                   s_fire;
    logic                   push;
    logic                   pop;

    logic [VEC_W-1:0]       base;
    logic [PATTERN_MAX-1:0] hit;
    logic [VEC_W-1:0]       moved;
    logic [VEC_W-1:0]       gen_a;
    logic [VEC_W-1:0]       gen_b;
    logic [VEC_W-1:0]       carry;
    logic [VEC_W-1:0]       stepped;
    logic                   matched_new;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign push     = s_fire && s_tlast;
    assign pop      = head_valid_reg && m_tready;

    assign base = in_row_reg ? live_reg : start_vec;

    always_comb
    begin
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            hit[p] = one_mask[p] ||
                     (lit_mask[p] &&
                      pat_bytes[p*slwm_pkg::BYTE_W +: slwm_pkg::BYTE_W] == s_tdata);
        end
    end

    // Matched positions advance by one, percents hold their position.
    assign moved = {base[PATTERN_MAX-1:0] & hit, 1'b0} |
                   {1'b0, base[PATTERN_MAX-1:0] & pct_mask};

    // Percent closure as a carry chain: generate = percent and live, propagate = percent.
    assign gen_a   = {1'b0, pct_mask};
    assign gen_b   = gen_a & moved;
    assign carry   = (gen_a + gen_b) ^ gen_a ^ gen_b;
    assign stepped = s_tuser ? base : (moved | carry);

    assign matched_new = stepped[len_eff];

    assign live_next   = s_fire ? stepped : live_reg;
    assign in_row_next = s_fire ? !s_tlast : in_row_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_match_next = head_match_reg;
        skid_valid_next = skid_valid_reg;
        skid_match_next = skid_match_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_match_next = skid_match_reg;
                skid_valid_next = push;
                skid_match_next = matched_new;
            end
            else
            begin
                head_valid_next = push;
                head_match_next = matched_new;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_match_next = matched_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= VEC_W'(1);
            in_row_reg     <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg       <= live_next;
            in_row_reg     <= in_row_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_match_reg <= head_match_next;
        skid_match_reg <= skid_match_next;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {7'b0, head_match_reg};

    `SLWM_ASSERT_SAME(a_skid_behind_head, skid_valid_reg, head_valid_reg, "skid entry without head")
    `SLWM_ASSERT_NEXT(a_result_queued, push, head_valid_reg, "row result not queued")
    `SLWM_ASSERT_NEXT(a_row_open, s_fire && !s_tlast, in_row_reg, "row not opened")
    `SLWM_ASSERT_NEXT(a_drain_empty, pop && !skid_valid_reg && !push, !head_valid_reg,
                      "stale result after drain")

endmodule

// ===== bench/sql_like_wildcard_matcher_checker.sv =====
// Checker for the LIKE matcher: tracks pattern writes, predicts match results, compares.
`timescale 1ns / 1ps

module sql_like_wildcard_matcher_checker
    import slwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] text_byte
    input  logic              s_tuser,   // [0] no_byte
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // [0] matched, [7:1] zero
    output int                fail_count,
    output int                pending
);

    logic [LEN_W-1:0]     len_reg;
    logic [DATA_W-1:0]    word_reg [NUM_WORDS];
    logic [PATTERN_MAX:0] live;
    logic                 in_row;
    logic                 match_q[$];
    logic                 want;
    reg_idx_t             widx;

    initial fail_count = 0;
    initial pending = 0;

    function automatic int unsigned active_len();
        int unsigned n;
        n = len_reg;
        if (n > PATTERN_MAX)
            n = PATTERN_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(int unsigned i);
        return word_reg[(i >> 3) % NUM_WORDS][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [PATTERN_MAX:0] close_over_percents(logic [PATTERN_MAX:0] v);
        for (int unsigned p = 0; p < active_len(); p++)
            if (v[p] && pattern_at(p) == WILD_ANY)
                v[p + 1] = 1'b1;
        return v;
    endfunction

    function automatic logic [PATTERN_MAX:0] consume_byte(logic [PATTERN_MAX:0] v,
                                                          logic [7:0] c);
        logic [PATTERN_MAX:0] nxt;
        logic [7:0]           pb;
        nxt = '0;
        for (int unsigned p = 0; p < active_len(); p++)
        begin
            pb = pattern_at(p);
            if (v[p])
            begin
                if (pb == WILD_ANY)
                    nxt[p] = 1'b1;
                else if (pb == WILD_ONE || pb == c)
                    nxt[p + 1] = 1'b1;
            end
        end
        return close_over_percents(nxt);
    endfunction

    task automatic report_fail(string msg);
        if (fail_count < 10)
            $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg = '0;
            foreach (word_reg[i])
                word_reg[i] = '0;
            in_row = 1'b0;
            live = '0;
            live[0] = 1'b1;
            match_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                widx = reg_idx_t'(paddr >> 3);
                if (widx == REG_LENGTH)
                    len_reg = pwdata[LEN_W-1:0];
                else if (widx >= REG_WORD0 && widx < REG_WORD0 + NUM_WORDS)
                    word_reg[widx - REG_WORD0] = pwdata;
            end

            // results leave before new ones are queued in the same cycle
            if (m_tvalid && m_tready)
            begin
                if (match_q.size() == 0)
                    report_fail($sformatf("result 0x%02h with no row pending", m_tdata));
                else
                begin
                    want = match_q.pop_front();
                    if (m_tdata !== {7'b0, want})
                        report_fail($sformatf("matched: expected %0d, got 0x%02h",
                                              want, m_tdata));
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (!in_row)
                    live = close_over_percents({{PATTERN_MAX{1'b0}}, 1'b1});
                if (!s_tuser)
                    live = consume_byte(live, s_tdata);
                if (s_tlast)
                begin
                    match_q.push_back(live[active_len()]);
                    in_row = 1'b0;
                end
                else
                    in_row = 1'b1;
            end

            pending = match_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top: clock, reset, pattern programming, text stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import slwm_pkg::*;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [7:0]        m_tdata;

    int                fail_count;
    int                pending;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                items_sent     = 0;
    int                pat_len_raw    = 0;
    logic [7:0]        pat_bytes [32];
    logic [7:0]        row_q[$];

    sql_like_wildcard_matcher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sql_like_wildcard_matcher_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 3;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_pattern(input int raw_len);
        logic [DATA_W-1:0] word;
        pat_len_raw = raw_len;
        apb_write(REG_LENGTH, DATA_W'(raw_len));
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            for (int k = 0; k < 8; k++)
                word[k * 8 +: 8] = pat_bytes[w * 8 + k];
            apb_write(REG_WORD0 + reg_idx_t'(w), word);
        end
    endtask

    task automatic load_pattern(input string s);
        foreach (pat_bytes[i])
            pat_bytes[i] = 8'h00;
        for (int i = 0; i < s.len(); i++)
            pat_bytes[i] = s[i];
        write_pattern(s.len());
    endtask

    task automatic send_item(input logic [7:0] b, input logic nb, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = nb;
        s_tlast  = lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // hold off requests until every pending match result has been taken
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] text_pick();
        if ($urandom_range(99) < 85)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    task automatic random_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            pat_len_raw = 0;
        else if (r < 20)
            pat_len_raw = 32;
        else if (r < 25)
            pat_len_raw = $urandom_range(63, 33);
        else
            pat_len_raw = $urandom_range(12, 1);
        foreach (pat_bytes[i])
        begin
            r = $urandom_range(99);
            if (r < 20)
                pat_bytes[i] = WILD_ANY;
            else if (r < 35)
                pat_bytes[i] = WILD_ONE;
            else if (r < 85)
                pat_bytes[i] = 8'h61 + 8'($urandom_range(2));
            else
                pat_bytes[i] = 8'($urandom_range(255));
        end
        write_pattern(pat_len_raw);
    endtask

    // mostly text shaped after the pattern, sometimes broken, sometimes noise
    task automatic build_row();
        int eff;
        row_q.delete();
        eff = (pat_len_raw > 32) ? 32 : pat_len_raw;
        if ($urandom_range(99) < 75)
        begin
            for (int i = 0; i < eff; i++)
            begin
                if (pat_bytes[i] == WILD_ANY)
                    repeat ($urandom_range(3)) row_q.push_back(text_pick());
                else if (pat_bytes[i] == WILD_ONE)
                    row_q.push_back(text_pick());
                else
                    row_q.push_back(pat_bytes[i]);
            end
            if ($urandom_range(99) < 25 && row_q.size() > 0)
            begin
                case ($urandom_range(2))
                    0: row_q[$urandom_range(row_q.size() - 1)] = text_pick();
                    1: void'(row_q.pop_back());
                    default: row_q.push_back(text_pick());
                endcase
            end
        end
        else
            repeat ($urandom_range(6)) row_q.push_back(text_pick());
    endtask

    task automatic send_row();
        logic tail_none;
        if (row_q.size() == 0)
            send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        else
        begin
            tail_none = ($urandom_range(99) < 8);
            foreach (row_q[i])
            begin
                if ($urandom_range(99) < 4)
                    send_item(8'($urandom_range(255)), 1'b1, 1'b0);
                send_item(row_q[i], 1'b0, !tail_none && i == row_q.size() - 1);
            end
            if (tail_none)
                send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        end
    endtask

    initial
    begin
        int idle_modes  [4] = '{0, 88, 0, 36};
        int stall_modes [4] = '{0, 0, 88, 36};
        int target;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty pattern: only empty text matches
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);

        // lone percent matches anything, empty text too
        drain();
        load_pattern("%");
        send_item(8'h5A, 1'b1, 1'b1);
        send_item("x", 1'b0, 1'b0);
        send_item("y", 1'b0, 1'b1);

        // empty items inside a row, one opening it
        drain();
        load_pattern("a_%c");
        send_item(8'h00, 1'b1, 1'b0);
        send_item("a", 1'b0, 1'b0);
        send_item("b", 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item("z", 1'b0, 1'b0);
        send_item("c", 1'b0, 1'b1);
        send_item("a", 1'b0, 1'b0);
        send_item("b", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);

        // pattern replaced while a row is open
        send_item("a", 1'b0, 1'b0);
        drain();
        load_pattern("ab%");
        send_item("b", 1'b0, 1'b1);

        // full length of percents
        drain();
        foreach (pat_bytes[i])
            pat_bytes[i] = WILD_ANY;
        write_pattern(32);
        send_item(8'h00, 1'b1, 1'b1);

        // oversized length clamps to the full pattern
        drain();
        pat_bytes[31] = 8'hFF;
        write_pattern(63);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            random_pattern();
            send_idle_pct  = idle_modes[ph % 4];
            recv_stall_pct = stall_modes[ph % 4];
            target = items_sent + 80;
            while (items_sent < target)
            begin
                build_row();
                send_row();
            end
        end

        drain();
        repeat (6) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/slwm_pkg.sv
design/slwm_cfg.sv
design/sql_like_wildcard_matcher.sv
bench/sql_like_wildcard_matcher_checker.sv
bench/tb.sv
